@@ design/buzzer_beep_sequencer_macros.svh @@
// Assertion macros used by the checker file.
`ifndef BUZZER_BEEP_SEQUENCER_MACROS_SVH
`define BUZZER_BEEP_SEQUENCER_MACROS_SVH

// Checked on every clock edge, quiet while reset is high.
`define BBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BBS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bbs_pkg.sv @@
package bbs_pkg;

  localparam int unsigned LEN_W   = 20;
  localparam int unsigned BOUND_W = 30;
  localparam int unsigned RATE_W  = 14;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned NUM_W   = 8;
  localparam int unsigned PH_W    = 8;

  localparam logic [LEN_W-1:0]   LEN_MAX       = 20'hFFFFF;
  localparam logic [NUM_W-1:0]   SER_MAX_BEEPS = 8'd64;
  localparam logic [BOUND_W-1:0] MS_PER_S      = 30'd1000;
  localparam logic [BOUND_W-1:0] MS_ROUND      = 30'd999;

  localparam logic [RATE_W-1:0]  RATE_RESET    = 14'd5400;
  localparam logic [LEN_W-1:0]   SERIES_RESET  = 20'd540;
  // phase bound is length * 1000 + 999, so floor(bound / 1000) is the length
  localparam logic [BOUND_W-1:0] BOUND_RESET   = 30'd540999;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SINGLE = 2'd1,
    CMD_SERIES = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_SINGLE_RATE  = 1'b0,
    REG_SERIES_TICKS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PH_W-1:0]    phases_left;
    logic [LEN_W-1:0]   tick_counter;
    logic [BOUND_W-1:0] phase_bound;
    logic               running;
    logic               pin_level;
  } bbs_state_t;

endpackage

@@ design/buzzer_beep_sequencer.sv @@
// channel   dir  payload
// s_axis    in   tuser: command[1:0]; tdata: length_ms[15:0], beep_number[23:16]
// m_axis    out  tdata: tone_out[0], active[1], zero[7:2]
// cfg       in   cfg_index 0 single_beep_rate, 1 series_phase_ticks
//
// One word per cycle while the output is not stalled; the result is registered
// and appears in the cycle after the word is taken. The rate multiply and the
// phase-end compare sit between the input port and the state register, which drives the output word directly.
// Input is taken whenever the output register is empty or drained that cycle.
// Reset clears the state, sets the phase bound to its default and restores the register defaults.
module buzzer_beep_sequencer import bbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // length_ms[15:0], beep_number[23:16]
  input  logic [1:0]        s_axis_tuser,   // command[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // tone_out[0], active[1], zero[7:2]
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [LEN_W-1:0]  cfg_data
);

  logic [RATE_W-1:0] single_beep_rate;
  logic [LEN_W-1:0]  series_phase_ticks;
  bbs_state_t        state;
  bbs_state_t        state_next;
  logic              take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  bbs_step u_step (
    .cur                (state),
    .command            (s_axis_tuser),
    .length_ms          (s_axis_tdata[15:0]),
    .beep_number        (s_axis_tdata[23:16]),
    .single_beep_rate   (single_beep_rate),
    .series_phase_ticks (series_phase_ticks),
    .nxt                (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      single_beep_rate   <= RATE_RESET;
      series_phase_ticks <= SERIES_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SINGLE_RATE:  single_beep_rate   <= cfg_data[RATE_W-1:0];
        REG_SERIES_TICKS: series_phase_ticks <= cfg_data;
        default:          single_beep_rate   <= single_beep_rate;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phases_left  <= '0;
      state.tick_counter <= '0;
      state.phase_bound  <= BOUND_RESET;
      state.running      <= 1'b0;
      state.pin_level    <= 1'b0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (take) begin
        state         <= state_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {6'b0, state.running, state.pin_level};

endmodule

@@ design/bbs_step.sv @@
module bbs_step import bbs_pkg::*; (
  input  bbs_state_t          cur,
  input  logic [1:0]          command,
  input  logic [MS_W-1:0]     length_ms,
  input  logic [NUM_W-1:0]    beep_number,
  input  logic [RATE_W-1:0]   single_beep_rate,
  input  logic [LEN_W-1:0]    series_phase_ticks,
  output bbs_state_t          nxt
);

  logic [BOUND_W-1:0] tick_scaled;
  logic               ends;
  logic               odd_phase;
  logic [PH_W-1:0]    ph_step;
  logic [LEN_W-1:0]   tc_step;
  logic [NUM_W-1:0]   n_sat;

  // tc >= floor(bound/1000), capped at LEN_MAX
  assign tick_scaled = (BOUND_W'(cur.tick_counter) + BOUND_W'(1)) * MS_PER_S;
  assign ends        = (tick_scaled > cur.phase_bound) || (cur.tick_counter == LEN_MAX);
  assign odd_phase   = cur.running && cur.phases_left[0];
  assign n_sat       = (beep_number > SER_MAX_BEEPS) ? SER_MAX_BEEPS : beep_number;

  always_comb begin
    if (ends) begin
      ph_step = (cur.phases_left != '0) ? cur.phases_left - PH_W'(1) : '0;
      tc_step = '0;
    end else begin
      ph_step = cur.phases_left;
      tc_step = cur.tick_counter + LEN_W'(1);
    end
  end

  always_comb begin
    nxt = cur;
    unique case (command)
      CMD_TICK: begin
        nxt.phases_left  = ph_step;
        nxt.tick_counter = tc_step;
        if (odd_phase) begin
          nxt.pin_level = ends ? cur.pin_level : ~cur.pin_level;
        end else begin
          nxt.pin_level = 1'b0;
          if (ph_step == '0) begin
            nxt.running      = 1'b0;
            nxt.tick_counter = '0;
          end
        end
      end
      CMD_SINGLE: begin
        nxt.phase_bound = BOUND_W'(single_beep_rate) * BOUND_W'(length_ms);
        nxt.phases_left = PH_W'(1);
        nxt.running     = 1'b1;
      end
      CMD_SERIES: begin
        nxt.phase_bound = BOUND_W'(series_phase_ticks) * MS_PER_S + MS_ROUND;
        nxt.phases_left = (n_sat == '0) ? '0 : {n_sat[PH_W-2:0], 1'b0} - PH_W'(1);
        nxt.running     = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

@@ design/bbs_checker.sv @@
`include "buzzer_beep_sequencer_macros.svh"

module bbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  `BBS_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")
  `BBS_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
  `BBS_ASSERT(a_ready_empty, !m_axis_tvalid |-> s_axis_tready, "not ready with empty output")
  `BBS_ASSERT(a_pin_idle, m_axis_tvalid |-> !(m_axis_tdata[0] && !m_axis_tdata[1]), "pin high while idle")
  `BBS_ASSERT(a_word_follows, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "accepted word gave no result")

endmodule

bind buzzer_beep_sequencer bbs_checker u_bbs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
